// File: sv/page_table_lru_replacement_macros.svh
// Assertion macros for the page table block.
`ifndef PAGE_TABLE_LRU_REPLACEMENT_MACROS_SVH
`define PAGE_TABLE_LRU_REPLACEMENT_MACROS_SVH
`ifndef ASSERT_OFF
`define PTL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PTL_ASSERT(label, clk, rst_n, prop, msg)
`define PTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/ptl_pkg.sv
// ----------------------------------------------------------------------------
// ptl_pkg
// Types, codes and defaults shared by the page table block.
// ----------------------------------------------------------------------------
`default_nettype none
package ptl_pkg;
    localparam int TableEntriesDefault   = 1024;
    localparam int PhysicalFramesDefault = 16;
    localparam int OpW    = 2;
    localparam int PageW  = 10;
    localparam int StatW  = 3;
    localparam int FrameW = 4;

    localparam logic [OpW-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OpW-1:0] OP_FAULT  = 2'd1;
    localparam logic [OpW-1:0] OP_DIRTY  = 2'd2;
    localparam logic [OpW-1:0] OP_UNUSED = 2'd3;

    localparam logic [StatW-1:0] ST_HIT           = 3'd0;
    localparam logic [StatW-1:0] ST_MISS          = 3'd1;
    localparam logic [StatW-1:0] ST_LOADED        = 3'd2;
    localparam logic [StatW-1:0] ST_DIRTY_SET     = 3'd3;
    localparam logic [StatW-1:0] ST_DIRTY_IGNORED = 3'd4;

    // Commands from controller to datapath.
    typedef struct packed {
        logic clear;     // zero one table entry of the pass after reset
        logic capture;   // latch request, start table read
        logic decide;    // evaluate and update table / frames
        logic victim;    // take the victim entry's dirty bit and clear the entry
        logic finish;    // load output register
    } ptl_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic need_victim;
        logic clear_done;
    } ptl_stat_t;
endpackage
`default_nettype wire

// File: sv/ptl_if.sv
// ----------------------------------------------------------------------------
// ptl_req_if / ptl_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface ptl_req_if;
    logic                        valid;
    logic                        ready;
    logic [ptl_pkg::OpW-1:0]     opcode;
    logic [ptl_pkg::PageW-1:0]   virtual_page;
    modport source (output valid, opcode, virtual_page, input ready);
    modport sink   (input valid, opcode, virtual_page, output ready);
endinterface

interface ptl_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [ptl_pkg::StatW-1:0]   status;
    logic [ptl_pkg::FrameW-1:0]  frame;
    logic                        was_dirty;
    logic                        wrote_back;
    modport source (output valid, status, frame, was_dirty, wrote_back, input ready);
    modport sink   (input valid, status, frame, was_dirty, wrote_back, output ready);
endinterface
`default_nettype wire

// File: sv/page_table_lru_replacement.sv
// ----------------------------------------------------------------------------
// page_table_lru_replacement
// Linear page table with least-recently-used frame replacement.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the page table, one entry
// per cycle, and holds ready low until every entry is cleared, before the
// first request transfer. After that one request is handled at a time: the
// table entry is read at the accepting edge, the decision and all table,
// owner and recency updates happen in the next cycle, a load that evicts
// reads the victim's entry at that decision edge and clears it in a further
// victim step through the single table port, and the result register is
// loaded in the output step. No new request is taken until the result of
// the last one is loaded. While an earlier result has not been taken, the
// last step waits, which stalls the request side as well.
`default_nettype none
module page_table_lru_replacement #(
    parameter int TABLE_ENTRIES   = ptl_pkg::TableEntriesDefault,
    parameter int PHYSICAL_FRAMES = ptl_pkg::PhysicalFramesDefault
) (
    input wire logic    clk,
    input wire logic    rst_n,
    ptl_req_if.sink     req,
    ptl_rsp_if.source   rsp
);
    ptl_pkg::ptl_cmd_t  cmd;
    ptl_pkg::ptl_stat_t stat;

    ptl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ptl_datapath #(
        .TABLE_ENTRIES   (TABLE_ENTRIES),
        .PHYSICAL_FRAMES (PHYSICAL_FRAMES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_opcode      (req.opcode),
        .in_page        (req.virtual_page),
        .out_status     (rsp.status),
        .out_frame      (rsp.frame),
        .out_was_dirty  (rsp.was_dirty),
        .out_wrote_back (rsp.wrote_back)
    );
endmodule
`default_nettype wire

// File: sv/ptl_ctrl.sv
// ----------------------------------------------------------------------------
// ptl_ctrl
// Request sequencer: table clearing, capture, decide, optional victim step,
// result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_table_lru_replacement_macros.svh"
module ptl_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ptl_pkg::ptl_cmd_t        cmd,
    input  wire ptl_pkg::ptl_stat_t  stat
);
    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_VICTIM = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // A request may enter while the previous result waits; it then waits in the
    // output state until the result register is free.
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = stat.need_victim ? S_VICTIM : S_OUT;
            end
            S_VICTIM:
            begin
                cmd.victim = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_next)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `PTL_ASSERT(a_onehot, clk, rst_n, $onehot(state_reg), "state not one-hot")
    `PTL_ASSERT_NEXT(a_cap, clk, rst_n, in_valid && in_ready, state_reg == S_DECIDE,
        "accepted request did not advance")
    `PTL_ASSERT_NEXT(a_fin, clk, rst_n, cmd.finish, out_valid_reg && state_reg == S_IDLE,
        "finish did not present result")
endmodule
`default_nettype wire

// File: sv/ptl_datapath.sv
// ----------------------------------------------------------------------------
// ptl_datapath
// Page table memories, frame owner and recency ranks, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_table_lru_replacement_macros.svh"
module ptl_datapath #(
    parameter int TABLE_ENTRIES   = ptl_pkg::TableEntriesDefault,
    parameter int PHYSICAL_FRAMES = ptl_pkg::PhysicalFramesDefault
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ptl_pkg::ptl_cmd_t           cmd,
    output ptl_pkg::ptl_stat_t               stat,
    input  wire logic [ptl_pkg::OpW-1:0]     in_opcode,
    input  wire logic [ptl_pkg::PageW-1:0]   in_page,
    output logic [ptl_pkg::StatW-1:0]        out_status,
    output logic [ptl_pkg::FrameW-1:0]       out_frame,
    output logic                             out_was_dirty,
    output logic                             out_wrote_back
);
    localparam int IdxW  = $clog2(TABLE_ENTRIES);
    localparam int FW    = $clog2(PHYSICAL_FRAMES);
    localparam int CntW  = $clog2(PHYSICAL_FRAMES + 1);

    // Table memory, one word per page: {frame, dirty, present}. A clearing
    // pass after reset zeroes it one entry per cycle.
    localparam int EW = FW + 2;

    logic [EW-1:0]   tbl [TABLE_ENTRIES];
    logic [EW-1:0]   rd_reg;
    logic [IdxW-1:0] idx_reg;
    logic [ptl_pkg::OpW-1:0] op_reg;
    logic [IdxW-1:0] clr_idx_reg;

    logic [IdxW-1:0] owner_reg [PHYSICAL_FRAMES];
    logic [FW-1:0]   rank_reg  [PHYSICAL_FRAMES];
    logic [CntW-1:0] count_reg;
    logic [IdxW-1:0] vpage_reg;
    logic [ptl_pkg::StatW-1:0] st_reg;
    logic [FW-1:0]   fr_reg;
    logic            wd_reg;
    logic            wb_reg;

    logic [FW-1:0]   rframe;
    logic            present;
    logic            full;
    logic [FW-1:0]   lru;
    logic [FW-1:0]   tgt;
    logic            promote;
    logic            do_load;

    assign rframe  = rd_reg[EW-1:2];
    assign present = rd_reg[0];
    assign full    = (count_reg == CntW'(PHYSICAL_FRAMES));

    always_comb
    begin
        lru = '0;
        for (int i = 0; i < PHYSICAL_FRAMES; i++)
        begin
            if (rank_reg[i] == FW'(PHYSICAL_FRAMES - 1))
            begin
                lru = FW'(i);
            end
        end
    end

    assign do_load = (op_reg == ptl_pkg::OP_FAULT) && !present;
    assign promote = (op_reg != ptl_pkg::OP_DIRTY) && (present || do_load);
    assign tgt     = present ? rframe : (full ? lru : count_reg[FW-1:0]);
    assign stat    = '{need_victim: do_load && full,
                       clear_done:  clr_idx_reg == IdxW'(TABLE_ENTRIES - 1)};

    // Table port: one read and one write per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_reg  <= tbl[IdxW'(in_page)];
            idx_reg <= IdxW'(in_page);
            op_reg  <= in_opcode;
        end
        else if (cmd.decide && stat.need_victim)
        begin
            rd_reg <= tbl[owner_reg[lru]];
        end
        if (cmd.clear)
        begin
            tbl[clr_idx_reg] <= '0;
        end
        else if (cmd.decide)
        begin
            if (op_reg == ptl_pkg::OP_DIRTY && present)
            begin
                tbl[idx_reg] <= {rframe, 1'b1, 1'b1};
            end
            else if (do_load)
            begin
                tbl[idx_reg] <= {tgt, 1'b0, 1'b1};
            end
        end
        else if (cmd.victim)
        begin
            tbl[vpage_reg] <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            // The owner is taken before this load replaces it.
            vpage_reg <= owner_reg[lru];
            if (do_load)
            begin
                owner_reg[tgt] <= idx_reg;
            end
            if (promote)
            begin
                for (int i = 0; i < PHYSICAL_FRAMES; i++)
                begin
                    if (FW'(i) == tgt)
                        rank_reg[i] <= '0;
                    else if ((present || full) && rank_reg[i] < rank_reg[tgt])
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                    else if (!present && !full && CntW'(i) < count_reg)
                        rank_reg[i] <= rank_reg[i] + 1'b1;
                end
            end
            wb_reg <= 1'b0;
            fr_reg <= '0;
            wd_reg <= 1'b0;
            if (op_reg == ptl_pkg::OP_DIRTY)
                st_reg <= present ? ptl_pkg::ST_DIRTY_SET : ptl_pkg::ST_DIRTY_IGNORED;
            else if (present)
            begin
                st_reg <= ptl_pkg::ST_HIT;
                fr_reg <= tgt;
                wd_reg <= rd_reg[1];
            end
            else if (do_load)
            begin
                st_reg <= ptl_pkg::ST_LOADED;
                fr_reg <= tgt;
            end
            else
                st_reg <= ptl_pkg::ST_MISS;
        end
        if (cmd.victim)
        begin
            wb_reg <= rd_reg[1];
        end
        if (cmd.finish)
        begin
            out_status     <= st_reg;
            out_frame      <= ptl_pkg::FrameW'(fr_reg);
            out_was_dirty  <= wd_reg;
            out_wrote_back <= wb_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            clr_idx_reg <= '0;
        end
        else
        begin
            if (cmd.decide && do_load && !full)
                count_reg <= count_reg + 1'b1;
            if (cmd.clear)
                clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    `PTL_ASSERT(a_cnt, clk, rst_n, count_reg <= CntW'(PHYSICAL_FRAMES), "count overflow")
    `PTL_ASSERT_NEXT(a_vic, clk, rst_n, cmd.decide && stat.need_victim, cmd.victim,
        "victim cycle skipped")
    `PTL_ASSERT(a_vfull, clk, rst_n, !cmd.victim || full, "eviction with a free frame")
endmodule
`default_nettype wire
